// ===== sv/lpd_pkg.sv =====
package lpd_pkg;

  // Channel layout and sample format.
  localparam int NUM_CHANNELS = 6;
  localparam int SAMPLE_BITS  = 14;
  localparam int WEIGHT_BITS  = 8;
  localparam int OUT_BITS     = 14;

  // Channels 0 and 1 are joystick axes, 2 through 5 are Hall sensors.
  localparam int JOY_ONE_CH   = 0;
  localparam int JOY_TWO_CH   = 1;
  localparam int HALL_FIRST   = 2;
  localparam int HALL_COUNT   = 4;
  localparam int HALL_SHIFT   = 2;

  // Moving average accumulator: w*s + (256-w)*old stays below 256 * 2^SAMPLE_BITS.
  localparam int ACC_BITS     = SAMPLE_BITS + WEIGHT_BITS + 1;
  localparam int SUM_BITS     = SAMPLE_BITS + HALL_SHIFT;

  // Linear position map: (reading*376 - 3297520) / 100.
  localparam int MAP_GAIN     = 376;
  localparam int MAP_ORIGIN   = 3297520;
  localparam int MAP_DIV      = 100;
  localparam int PROD_BITS    = OUT_BITS + 9;
  localparam int DIFF_BITS    = 22;
  // Division by 100 as a multiply by a rounded-up reciprocal; exact for DIFF_BITS inputs.
  localparam int RECIP_SHIFT  = 29;
  localparam int RECIP        = (1 << RECIP_SHIFT) / MAP_DIV + 1;
  localparam int RECIP_BITS   = 23;
  localparam int QPROD_BITS   = DIFF_BITS + RECIP_BITS;
  localparam int QUOT_BITS    = QPROD_BITS - RECIP_SHIFT;

  // Queue sizes.
  localparam int MIDQ_DEPTH   = 4;
  localparam int MIDQ_AW      = 2;
  localparam int OUTQ_DEPTH   = 8;
  localparam int OUTQ_AW      = 3;

  localparam int REG_IDX_BITS = 3;

  typedef logic [SAMPLE_BITS-1:0]  sample_t;
  typedef sample_t [NUM_CHANNELS-1:0] chan_vec_t;
  typedef logic [OUT_BITS-1:0]     word_t;

  localparam word_t OUT_MAX   = '1;
  localparam word_t DUTY_IDLE = word_t'(1);

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_EMA_WEIGHT     = 3'd0,
    REG_LOWER_LIMIT    = 3'd1,
    REG_UPPER_LIMIT    = 3'd2,
    REG_UPPER_CLAMP    = 3'd3,
    REG_DRIVE_THRESHOLD = 3'd4,
    REG_DRIVE_OFFSET   = 3'd5,
    REG_DRIVE_SPAN     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] ema_weight;
    word_t                  lower_limit;
    word_t                  upper_limit;
    word_t                  upper_clamp;
    word_t                  drive_threshold;
    word_t                  drive_offset;
    word_t                  drive_span;
  } cfg_t;

  typedef struct packed {
    word_t up_duty;
    word_t down_duty;
    word_t clamped_reading;
    word_t position_from_bottom;
    word_t joystick_one_filtered;
    word_t joystick_two_filtered;
  } result_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ===== sv/levitation_position_drive.sv =====
// Filter, position estimate and coil drive for a magnetic levitator. Each input word is one
// ADC sequence of six 14-bit samples; each produces exactly one result word. Every channel
// runs through an integer exponential moving average, new = (w*sample + (256-w)*old)/256,
// whose state is cleared by reset. The four Hall channels (2..5) are averaged, held inside
// the lower limit and the upper limit (the lower limit is checked first; a reading at or
// above the upper limit becomes the upper clamp value), mapped to a position with
// (reading*376 - 3297520)/100 saturated to 0..16383, and turned into up/down coil compare
// values: above the drive threshold the up duty is position plus offset (saturated) and the
// down duty is 1, otherwise the up duty is 1 and the down duty is span minus position,
// floored at 0. The block accepts one word per clock and delivers one result per clock
// sustained while out_pop stays high; each word passes through the middle queue and
// then the back-end pipeline (limit stage, gain multiply, reciprocal multiply for the
// divide by 100, then drive logic into the result queue). The filter recurrence
// closes combinationally in the front end, so back-to-back words are fine.
// A four-word queue sits between the filter and the back end, and an eight-word result
// queue holds finished words; in_full rises only when both back up. Configuration is
// written through cfg_we/cfg_index/cfg_wdata and should only change while no word is in
// flight; an index beyond the register list is ignored, and the weight takes the low
// eight bits of the data.
module levitation_position_drive (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lpd_pkg::REG_IDX_BITS-1:0]    cfg_index,
  input  logic [lpd_pkg::OUT_BITS-1:0]        cfg_wdata,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [lpd_pkg::SAMPLE_BITS-1:0]     in_sample_ch0,
  input  logic [lpd_pkg::SAMPLE_BITS-1:0]     in_sample_ch1,
  input  logic [lpd_pkg::SAMPLE_BITS-1:0]     in_sample_ch2,
  input  logic [lpd_pkg::SAMPLE_BITS-1:0]     in_sample_ch3,
  input  logic [lpd_pkg::SAMPLE_BITS-1:0]     in_sample_ch4,
  input  logic [lpd_pkg::SAMPLE_BITS-1:0]     in_sample_ch5,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [lpd_pkg::OUT_BITS-1:0]        out_up_duty,
  output logic [lpd_pkg::OUT_BITS-1:0]        out_down_duty,
  output logic [lpd_pkg::OUT_BITS-1:0]        out_clamped_reading,
  output logic [lpd_pkg::OUT_BITS-1:0]        out_position_from_bottom,
  output logic [lpd_pkg::OUT_BITS-1:0]        out_joystick_one_filtered,
  output logic [lpd_pkg::OUT_BITS-1:0]        out_joystick_two_filtered
);
  import lpd_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  chan_vec_t  samples;
  chan_vec_t  filt_data;
  chan_vec_t  mid_data;
  q_status_t  mid_status;
  logic       in_accept;
  logic       filt_push;
  logic       mid_pop;
  result_t    result;

  // Register writes. Anything outside the register list falls through untouched.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_EMA_WEIGHT:      cfg_nxt.ema_weight      = cfg_wdata[WEIGHT_BITS-1:0];
        REG_LOWER_LIMIT:     cfg_nxt.lower_limit     = cfg_wdata;
        REG_UPPER_LIMIT:     cfg_nxt.upper_limit     = cfg_wdata;
        REG_UPPER_CLAMP:     cfg_nxt.upper_clamp     = cfg_wdata;
        REG_DRIVE_THRESHOLD: cfg_nxt.drive_threshold = cfg_wdata;
        REG_DRIVE_OFFSET:    cfg_nxt.drive_offset    = cfg_wdata;
        REG_DRIVE_SPAN:      cfg_nxt.drive_span      = cfg_wdata;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ema_weight      <= WEIGHT_BITS'(100);
      cfg_r.lower_limit     <= OUT_BITS'(8770);
      cfg_r.upper_limit     <= OUT_BITS'(12780);
      cfg_r.upper_clamp     <= OUT_BITS'(12750);
      cfg_r.drive_threshold <= OUT_BITS'(4500);
      cfg_r.drive_offset    <= OUT_BITS'(1000);
      cfg_r.drive_span      <= OUT_BITS'(15000);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign samples   = {in_sample_ch5, in_sample_ch4, in_sample_ch3,
                      in_sample_ch2, in_sample_ch1, in_sample_ch0};
  assign in_full   = mid_status.full;
  assign in_accept = in_push && !mid_status.full;

  // Front end: the moving-average filters, updated on every accepted word.
  lpd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept_i  (in_accept),
    .samples_i (samples),
    .weight_i  (cfg_r.ema_weight),
    .push_o    (filt_push),
    .data_o    (filt_data)
  );

  // Decoupling queue between filter and position pipeline.
  lpd_midq u_midq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (filt_push),
    .wdata_i  (filt_data),
    .pop_i    (mid_pop),
    .rdata_o  (mid_data),
    .status_o (mid_status)
  );

  // Back end: average, limits, position map, coil duties and the result queue.
  lpd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg_r),
    .mid_status_i (mid_status),
    .mid_data_i   (mid_data),
    .mid_pop_o    (mid_pop),
    .out_pop_i    (out_pop),
    .out_empty_o  (out_empty),
    .out_data_o   (result)
  );

  assign out_up_duty               = result.up_duty;
  assign out_down_duty             = result.down_duty;
  assign out_clamped_reading       = result.clamped_reading;
  assign out_position_from_bottom  = result.position_from_bottom;
  assign out_joystick_one_filtered = result.joystick_one_filtered;
  assign out_joystick_two_filtered = result.joystick_two_filtered;

endmodule

// ===== sv/lpd_front.sv =====
module lpd_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept_i,
  input  lpd_pkg::chan_vec_t       samples_i,
  input  logic [lpd_pkg::WEIGHT_BITS-1:0] weight_i,
  output logic                     push_o,
  output lpd_pkg::chan_vec_t       data_o
);
  import lpd_pkg::*;

  chan_vec_t filt_r, filt_nxt;
  logic [ACC_BITS-1:0]    acc [NUM_CHANNELS];
  logic [WEIGHT_BITS:0]   keep_w;

  // Each channel keeps (256 - w)/256 of its old value and takes w/256 of the new sample.
  always_comb begin
    keep_w = (WEIGHT_BITS+1)'(1 << WEIGHT_BITS) - {1'b0, weight_i};
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      acc[k] = ACC_BITS'({1'b0, weight_i}) * ACC_BITS'(samples_i[k])
             + ACC_BITS'(keep_w) * ACC_BITS'(filt_r[k]);
      filt_nxt[k] = accept_i ? acc[k][WEIGHT_BITS +: SAMPLE_BITS] : filt_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= '0;
    end else begin
      filt_r <= filt_nxt;
    end
  end

  assign push_o = accept_i;
  assign data_o = filt_nxt;

endmodule

// ===== sv/lpd_midq.sv =====
module lpd_midq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  lpd_pkg::chan_vec_t  wdata_i,
  input  logic                pop_i,
  output lpd_pkg::chan_vec_t  rdata_o,
  output lpd_pkg::q_status_t  status_o
);
  import lpd_pkg::*;

  chan_vec_t            mem [MIDQ_DEPTH];
  logic [MIDQ_AW-1:0]   wptr_r, wptr_nxt;
  logic [MIDQ_AW-1:0]   rptr_r, rptr_nxt;
  logic [MIDQ_AW:0]     cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = push_i ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop_i  ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + (MIDQ_AW+1)'(push_i) - (MIDQ_AW+1)'(pop_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem[wptr_r] <= wdata_i;
    end
  end

  assign rdata_o        = mem[rptr_r];
  assign status_o.empty = (cnt_r == '0);
  assign status_o.full  = (cnt_r == (MIDQ_AW+1)'(MIDQ_DEPTH));

endmodule

// ===== sv/lpd_back.sv =====
module lpd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  lpd_pkg::cfg_t       cfg_i,
  input  lpd_pkg::q_status_t  mid_status_i,
  input  lpd_pkg::chan_vec_t  mid_data_i,
  output logic                mid_pop_o,
  input  logic                out_pop_i,
  output logic                out_empty_o,
  output lpd_pkg::result_t    out_data_o
);
  import lpd_pkg::*;

  typedef struct packed {
    word_t reading;
    word_t joy_one;
    word_t joy_two;
  } side_t;

  typedef struct packed {
    logic                 positive;
    logic [DIFF_BITS-1:0] diff;
    side_t                side;
  } s2_t;

  typedef struct packed {
    logic                  positive;
    logic [QPROD_BITS-1:0] qprod;
    side_t                 side;
  } s3_t;

  logic   v1_r, v2_r, v3_r;
  side_t  s1_r, s1_nxt;
  s2_t    s2_r, s2_nxt;
  s3_t    s3_r, s3_nxt;

  result_t               outq [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]    owptr_r, orptr_r;
  logic [OUTQ_AW:0]      ocnt_r;
  logic [OUTQ_AW+1:0]    occ;
  logic                  take, opop;

  logic [SUM_BITS-1:0]   hall_sum;
  word_t                 avg;
  logic [PROD_BITS-1:0]  gain_prod;
  logic [QUOT_BITS-1:0]  quot;
  word_t                 pos;
  logic [OUT_BITS:0]     up_sum;
  result_t               res;

  // Issue only with room reserved in the result queue for everything in flight.
  always_comb begin
    occ  = (OUTQ_AW+2)'(ocnt_r) + (OUTQ_AW+2)'(v1_r) + (OUTQ_AW+2)'(v2_r)
         + (OUTQ_AW+2)'(v3_r);
    take = !mid_status_i.empty && (occ < (OUTQ_AW+2)'(OUTQ_DEPTH));
    opop = out_pop_i && (ocnt_r != '0);
  end
  assign mid_pop_o = take;

  // Stage 1: Hall average and hard limits. The lower limit is tested first.
  always_comb begin
    hall_sum = '0;
    for (int k = 0; k < HALL_COUNT; k++) begin
      hall_sum = hall_sum + SUM_BITS'(mid_data_i[HALL_FIRST + k]);
    end
    avg = hall_sum[SUM_BITS-1 -: OUT_BITS];
    if (avg > cfg_i.lower_limit) begin
      s1_nxt.reading = (avg < cfg_i.upper_limit) ? avg : cfg_i.upper_clamp;
    end else begin
      s1_nxt.reading = cfg_i.lower_limit;
    end
    s1_nxt.joy_one = mid_data_i[JOY_ONE_CH];
    s1_nxt.joy_two = mid_data_i[JOY_TWO_CH];
  end

  // Stage 2: gain and origin. A reading at or below the origin maps to zero.
  always_comb begin
    gain_prod       = PROD_BITS'(s1_r.reading) * PROD_BITS'(MAP_GAIN);
    s2_nxt.positive = gain_prod > PROD_BITS'(MAP_ORIGIN);
    s2_nxt.diff     = DIFF_BITS'(gain_prod - PROD_BITS'(MAP_ORIGIN));
    s2_nxt.side     = s1_r;
  end

  // Stage 3: divide by 100 through the reciprocal multiply.
  always_comb begin
    s3_nxt.positive = s2_r.positive;
    s3_nxt.qprod    = QPROD_BITS'(s2_r.diff) * QPROD_BITS'(RECIP);
    s3_nxt.side     = s2_r.side;
  end

  // Stage 4: saturate the position and form the coil duties.
  always_comb begin
    quot = s3_r.qprod[RECIP_SHIFT +: QUOT_BITS];
    if (!s3_r.positive) begin
      pos = '0;
    end else if (quot > QUOT_BITS'(OUT_MAX)) begin
      pos = OUT_MAX;
    end else begin
      pos = quot[OUT_BITS-1:0];
    end
    up_sum = {1'b0, pos} + {1'b0, cfg_i.drive_offset};
    if (pos > cfg_i.drive_threshold) begin
      res.up_duty   = up_sum[OUT_BITS] ? OUT_MAX : up_sum[OUT_BITS-1:0];
      res.down_duty = DUTY_IDLE;
    end else begin
      res.up_duty   = DUTY_IDLE;
      res.down_duty = (cfg_i.drive_span >= pos) ? cfg_i.drive_span - pos : '0;
    end
    res.clamped_reading       = s3_r.side.reading;
    res.position_from_bottom  = pos;
    res.joystick_one_filtered = s3_r.side.joy_one;
    res.joystick_two_filtered = s3_r.side.joy_two;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      owptr_r <= '0;
      orptr_r <= '0;
      ocnt_r  <= '0;
    end else begin
      v1_r    <= take;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      owptr_r <= v3_r ? owptr_r + 1'b1 : owptr_r;
      orptr_r <= opop ? orptr_r + 1'b1 : orptr_r;
      ocnt_r  <= ocnt_r + (OUTQ_AW+1)'(v3_r) - (OUTQ_AW+1)'(opop);
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
    s3_r <= s3_nxt;
    if (v3_r) begin
      outq[owptr_r] <= res;
    end
  end

  assign out_empty_o = (ocnt_r == '0);
  assign out_data_o  = outq[orptr_r];

endmodule

// ===== sv/lpd_checker.sv =====
module lpd_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_empty,
  input logic                                out_pop,
  input logic [lpd_pkg::OUT_BITS-1:0]        out_up_duty,
  input logic [lpd_pkg::OUT_BITS-1:0]        out_down_duty,
  input logic [lpd_pkg::OUT_BITS-1:0]        out_clamped_reading,
  input logic [lpd_pkg::OUT_BITS-1:0]        out_position_from_bottom,
  input logic [lpd_pkg::OUT_BITS-1:0]        out_joystick_one_filtered,
  input logic [lpd_pkg::OUT_BITS-1:0]        out_joystick_two_filtered
);
  import lpd_pkg::*;

  // Reset leaves no result word behind.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // A waiting word that is not popped stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_up_duty)
      && $stable(out_down_duty) && $stable(out_position_from_bottom)
      && $stable(out_clamped_reading) && $stable(out_joystick_one_filtered)
      && $stable(out_joystick_two_filtered)))
    else $error("waiting result changed before it was popped");

  // Only one coil is driven at a time; the idle coil sits at a duty of one.
  a_one_coil: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_up_duty == DUTY_IDLE || out_down_duty == DUTY_IDLE))
    else $error("both coils driven");

  // A reading at or below the map origin must give position zero.
  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (int'(out_clamped_reading) * MAP_GAIN <= MAP_ORIGIN))
      |-> (out_position_from_bottom == '0))
    else $error("position nonzero below the map origin");

endmodule

bind levitation_position_drive lpd_checker u_lpd_checker (.*);

// ===== test/levitation_position_drive_tb.sv =====
module levitation_position_drive_tb;
  import lpd_pkg::*;

  // Constants of the position map and the moving average, kept here so the
  // prediction does not lean on the block's own package arithmetic.
  localparam int POS_GAIN    = 376;
  localparam int POS_ORIGIN  = 3297520;
  localparam int POS_DIV     = 100;
  localparam int WORD_TOP    = 16383;
  localparam int EMA_SCALE   = 256;

  // The register port is three bits wide, so one index past the register list
  // exists and must be ignored by the block.
  localparam logic [REG_IDX_BITS-1:0] UNUSED_INDEX = 3'd7;

  // Settle time given before a register write and before the end of the run.
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS   = 166;
  localparam int REPORT_LIMIT  = 40;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  logic [REG_IDX_BITS-1:0] cfg_index;
  logic [OUT_BITS-1:0]     cfg_wdata;
  logic      in_push;
  logic      in_full;
  chan_vec_t in_samples;
  logic      out_empty;
  logic      out_pop = 1'b0;
  result_t   out_word;

  always #4 clk = ~clk;

  levitation_position_drive DUT (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cfg_we                    (cfg_we),
    .cfg_index                 (cfg_index),
    .cfg_wdata                 (cfg_wdata),
    .in_push                   (in_push),
    .in_full                   (in_full),
    .in_sample_ch0             (in_samples[0]),
    .in_sample_ch1             (in_samples[1]),
    .in_sample_ch2             (in_samples[2]),
    .in_sample_ch3             (in_samples[3]),
    .in_sample_ch4             (in_samples[4]),
    .in_sample_ch5             (in_samples[5]),
    .out_empty                 (out_empty),
    .out_pop                   (out_pop),
    .out_up_duty               (out_word.up_duty),
    .out_down_duty             (out_word.down_duty),
    .out_clamped_reading       (out_word.clamped_reading),
    .out_position_from_bottom  (out_word.position_from_bottom),
    .out_joystick_one_filtered (out_word.joystick_one_filtered),
    .out_joystick_two_filtered (out_word.joystick_two_filtered)
  );

  // Shadow copy of the filter state and of the register file. Both are
  // updated only when the block itself takes a word or a register write.
  sample_t ema_state [NUM_CHANNELS];
  cfg_t    shadow_cfg;

  // Drive results still owed by the block, oldest first.
  result_t drive_results_due [$];

  int error_count    = 0;
  int words_sent     = 0;
  int results_checked = 0;
  int reg_writes     = 0;
  int settings_used  = 0;

  // Sender burst bookkeeping. push_held says that in_push is still high from
  // the previous word, so the next edge would take it again if left alone.
  bit push_held  = 1'b0;
  int burst_left = 0;

  function automatic word_t clip_word(input longint v);
    if (v < 0) return '0;
    if (v > WORD_TOP) return word_t'(WORD_TOP);
    return word_t'(v);
  endfunction

  // Works out the result word for one ADC sequence. With commit set the
  // filter state moves on; without it this is only a look ahead, which the
  // boundary tests use to place a limit exactly on the coming reading.
  function automatic result_t compute_drive(input chan_vec_t s, input bit commit);
    logic [31:0] acc;
    logic [31:0] hall_sum;
    sample_t     nxt [NUM_CHANNELS];
    word_t       avg;
    word_t       reading;
    word_t       pos;
    longint      mapped;
    result_t     r;
    hall_sum = '0;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      acc = 32'(shadow_cfg.ema_weight) * 32'(s[k])
          + (32'(EMA_SCALE) - 32'(shadow_cfg.ema_weight)) * 32'(ema_state[k]);
      nxt[k] = sample_t'(acc / EMA_SCALE);
    end
    for (int k = 2; k < NUM_CHANNELS; k++) hall_sum += 32'(nxt[k]);
    avg = word_t'(hall_sum / 4);

    // The lower limit wins; only a reading above it is held to the upper one.
    if (avg > shadow_cfg.lower_limit) begin
      reading = (avg < shadow_cfg.upper_limit) ? avg : shadow_cfg.upper_clamp;
    end else begin
      reading = shadow_cfg.lower_limit;
    end

    mapped = (longint'(reading) * POS_GAIN - POS_ORIGIN) / POS_DIV;
    pos = clip_word(mapped);

    if (pos > shadow_cfg.drive_threshold) begin
      r.up_duty   = clip_word(longint'(pos) + longint'(shadow_cfg.drive_offset));
      r.down_duty = word_t'(1);
    end else begin
      r.up_duty   = word_t'(1);
      r.down_duty = clip_word(longint'(shadow_cfg.drive_span) - longint'(pos));
    end
    r.clamped_reading       = reading;
    r.position_from_bottom  = pos;
    r.joystick_one_filtered = nxt[0];
    r.joystick_two_filtered = nxt[1];
    if (commit) begin
      for (int k = 0; k < NUM_CHANNELS; k++) ema_state[k] = nxt[k];
    end
    return r;
  endfunction

  function automatic void compare_field(input string name, input word_t want,
                                        input word_t got);
    if (want !== got) begin
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end else if (error_count == REPORT_LIMIT + 1) begin
        $display("%0t: further field errors are counted but not listed", $time);
      end
    end
  endfunction

  // Result checker. Outputs are read at the rising edge, before the block's
  // own updates for that edge land, so a word popped here is the one that
  // was presented during the cycle.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (drive_results_due.size() == 0) begin
        error_count++;
        $display("%0t: result word with none expected, up_duty actual %0d", $time,
                 out_word.up_duty);
      end else begin
        want = drive_results_due.pop_front();
        results_checked++;
        compare_field("up_duty", want.up_duty, out_word.up_duty);
        compare_field("down_duty", want.down_duty, out_word.down_duty);
        compare_field("clamped_reading", want.clamped_reading, out_word.clamped_reading);
        compare_field("position_from_bottom", want.position_from_bottom,
                      out_word.position_from_bottom);
        compare_field("joystick_one_filtered", want.joystick_one_filtered,
                      out_word.joystick_one_filtered);
        compare_field("joystick_two_filtered", want.joystick_two_filtered,
                      out_word.joystick_two_filtered);
      end
    end
  end

  // Receiver stall pattern. It runs on its own clock of segments: some where
  // every result is taken at once, some with coin-flip pops, some that take
  // one word in five, and some long stalls that let the result queue fill up
  // and push back on the input side.
  int pop_mode = 0;
  int pop_left = 0;
  int pop_tick = 0;

  always @(negedge clk) begin
    if (pop_left == 0) begin
      pop_mode = $urandom_range(0, 3);
      pop_left = $urandom_range(16, 200);
      pop_tick = 0;
    end
    pop_left--;
    pop_tick++;
    case (pop_mode)
      0:       out_pop <= 1'b1;
      1:       out_pop <= ($urandom_range(0, 1) == 1);
      2:       out_pop <= ($urandom_range(0, 4) == 0);
      default: out_pop <= ((pop_tick % 24) >= 20);
    endcase
  end

  // Drops in_push if the last word left it high. Anything other than sending
  // the next word must call this first, or the block takes a copy.
  task automatic release_push();
    if (push_held) begin
      @(negedge clk);
      in_push   <= 1'b0;
      push_held = 1'b0;
    end
  endtask

  // Sends one ADC sequence. Words go out in bursts of random length; between
  // bursts the sender may pause for a random number of cycles, and about a
  // third of the bursts follow on with no pause at all.
  task automatic send_word(input chan_vec_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_push   <= 1'b0;
        push_held = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_samples <= s;
    if (!push_held) in_push <= 1'b1;
    push_held = 1'b1;
    do @(posedge clk); while (in_full);
    drive_results_due.push_back(compute_drive(s, 1'b1));
    words_sent++;
    burst_left--;
  endtask

  // Register write. The block must be idle, so the sender stops, every owed
  // result is collected, and the pipeline is given time to settle first.
  task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                           input logic [OUT_BITS-1:0] data);
    release_push();
    while (drive_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_EMA_WEIGHT:      shadow_cfg.ema_weight      = data[WEIGHT_BITS-1:0];
      REG_LOWER_LIMIT:     shadow_cfg.lower_limit     = data;
      REG_UPPER_LIMIT:     shadow_cfg.upper_limit     = data;
      REG_UPPER_CLAMP:     shadow_cfg.upper_clamp     = data;
      REG_DRIVE_THRESHOLD: shadow_cfg.drive_threshold = data;
      REG_DRIVE_OFFSET:    shadow_cfg.drive_offset    = data;
      REG_DRIVE_SPAN:      shadow_cfg.drive_span      = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Writes the whole register file in one go; the weight carries junk in the
  // bits above its width, which the block must drop.
  task automatic load_settings(input int w, input int lo, input int hi, input int clamp,
                               input int thr, input int offs, input int span);
    logic [OUT_BITS-1:0] wdata;
    wdata = {6'($urandom_range(0, 63)), 8'(w)};
    write_reg(REG_EMA_WEIGHT, wdata);
    write_reg(REG_LOWER_LIMIT, OUT_BITS'(lo));
    write_reg(REG_UPPER_LIMIT, OUT_BITS'(hi));
    write_reg(REG_UPPER_CLAMP, OUT_BITS'(clamp));
    write_reg(REG_DRIVE_THRESHOLD, OUT_BITS'(thr));
    write_reg(REG_DRIVE_OFFSET, OUT_BITS'(offs));
    write_reg(REG_DRIVE_SPAN, OUT_BITS'(span));
    settings_used++;
  endtask

  function automatic sample_t near_level(input int level, input int spread);
    int v;
    v = level + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > WORD_TOP) v = WORD_TOP;
    return sample_t'(v);
  endfunction

  // All four Hall channels at one level, the joystick axes as given.
  function automatic chan_vec_t hall_level(input int level, input int joy_one,
                                           input int joy_two);
    chan_vec_t s;
    s[0] = sample_t'(joy_one);
    s[1] = sample_t'(joy_two);
    for (int k = 2; k < NUM_CHANNELS; k++) s[k] = sample_t'(level);
    return s;
  endfunction

  // Straight after reset with the reset register values: an all-zero word,
  // a run at full scale so the filter climbs from zero, and opposite
  // joystick extremes, then a mid-scale Hall level with both axes at full scale.
  task automatic test_reset_values();
    send_word(hall_level(0, 0, 0));
    send_word(hall_level(WORD_TOP, WORD_TOP, 0));
    send_word(hall_level(WORD_TOP, 0, WORD_TOP));
    send_word(hall_level(11000, WORD_TOP, WORD_TOP));
  endtask

  // Readings exactly on the lower limit, exactly on the upper limit and a
  // position exactly on the drive threshold. The limit is placed on the
  // reading that the next word will produce, so equality is hit for sure.
  task automatic test_limit_edges();
    chan_vec_t s;
    result_t   ahead;
    write_reg(REG_EMA_WEIGHT, {6'b101010, 8'hFF});
    s = hall_level(11000, 5000, 9000);
    send_word(s);
    send_word(s);

    ahead = compute_drive(s, 1'b0);
    write_reg(REG_LOWER_LIMIT, ahead.clamped_reading);
    send_word(s);
    write_reg(REG_LOWER_LIMIT, 14'd8770);

    ahead = compute_drive(s, 1'b0);
    write_reg(REG_UPPER_LIMIT, ahead.clamped_reading);
    send_word(s);
    write_reg(REG_UPPER_LIMIT, 14'd12780);

    ahead = compute_drive(s, 1'b0);
    write_reg(REG_DRIVE_THRESHOLD, ahead.position_from_bottom);
    send_word(s);
  endtask

  // Saturation at both ends: a position past full scale with the up duty
  // overflowing and a reading below the map origin, then inverted limits and
  // finally a frozen filter (weight zero).
  task automatic test_saturation();
    load_settings(255, 0, WORD_TOP, WORD_TOP, 0, WORD_TOP, 0);
    send_word(hall_level(WORD_TOP, WORD_TOP, WORD_TOP));
    send_word(hall_level(WORD_TOP, 0, 0));
    send_word(hall_level(0, 0, 0));
    send_word(hall_level(3000, 100, 200));

    load_settings(255, WORD_TOP, 0, 5000, WORD_TOP, 0, WORD_TOP);
    send_word(hall_level(200, 1, 2));
    send_word(hall_level(9000, 3, 4));
    send_word(hall_level(WORD_TOP, 5, 6));

    write_reg(REG_EMA_WEIGHT, 14'd0);
    write_reg(UNUSED_INDEX, 14'h3FFF);
    send_word(hall_level(WORD_TOP, WORD_TOP, WORD_TOP));
    send_word(hall_level(0, 0, 0));
  endtask

  // Random phases. Each one loads a register setting and then sends runs of
  // words whose Hall samples sit around a level near the clamp band, so the
  // filter settles and the reading sweeps through the limits, threshold and
  // both saturation regions. About one word in ten is pure noise.
  task automatic test_random_phases();
    chan_vec_t s;
    int lo;
    int hi;
    int w;
    int band_lo;
    int band_hi;
    int target;
    int spread;
    int run_left;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) begin
        load_settings(100, 8770, 12780, 12750, 4500, 1000, 15000);
      end else begin
        case ($urandom_range(0, 3))
          0:       w = 255;
          1:       w = $urandom_range(1, 255);
          default: w = $urandom_range(64, 255);
        endcase
        if ($urandom_range(0, 3) == 0) begin
          lo = $urandom_range(0, WORD_TOP);
          hi = $urandom_range(0, WORD_TOP);
        end else begin
          lo = $urandom_range(7000, 11000);
          hi = $urandom_range(lo + 1, WORD_TOP);
        end
        load_settings(w, lo, hi, $urandom_range(0, WORD_TOP), $urandom_range(0, WORD_TOP),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000)
                                                  : $urandom_range(0, WORD_TOP),
                      $urandom_range(0, WORD_TOP));
      end
      if (shadow_cfg.lower_limit < shadow_cfg.upper_limit) begin
        band_lo = (shadow_cfg.lower_limit > 1500) ? shadow_cfg.lower_limit - 1500 : 0;
        band_hi = (shadow_cfg.upper_limit + 1500 > WORD_TOP) ? WORD_TOP
                                                             : shadow_cfg.upper_limit + 1500;
      end else begin
        band_lo = 0;
        band_hi = WORD_TOP;
      end
      run_left = 0;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 40);
          spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3000)
                                               : $urandom_range(0, 200);
          target = ($urandom_range(0, 3) == 0) ? $urandom_range(0, WORD_TOP)
                                               : $urandom_range(band_lo, band_hi);
        end
        if ($urandom_range(0, 9) == 0) begin
          for (int k = 0; k < NUM_CHANNELS; k++) s[k] = sample_t'($urandom_range(0, WORD_TOP));
        end else begin
          for (int k = 0; k < 2; k++) begin
            if ($urandom_range(0, 7) == 0) s[k] = ($urandom_range(0, 1) == 1) ? '1 : '0;
            else s[k] = sample_t'($urandom_range(0, WORD_TOP));
          end
          for (int k = 2; k < NUM_CHANNELS; k++) s[k] = near_level(target, spread);
        end
        send_word(s);
        run_left--;
      end
    end
  endtask

  // Hard stop in case the block hangs or never drains.
  initial begin
    #3_200_000;
    $display("levitation_position_drive: mismatch");
    $finish;
  end

  initial begin : main_sequence
    int waited;
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_wdata  <= '0;
    in_push    <= 1'b0;
    in_samples <= '0;
    for (int k = 0; k < NUM_CHANNELS; k++) ema_state[k] = '0;
    shadow_cfg.ema_weight      = 8'd100;
    shadow_cfg.lower_limit     = 14'd8770;
    shadow_cfg.upper_limit     = 14'd12780;
    shadow_cfg.upper_clamp     = 14'd12750;
    shadow_cfg.drive_threshold = 14'd4500;
    shadow_cfg.drive_offset    = 14'd1000;
    shadow_cfg.drive_span      = 14'd15000;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    settings_used = 1;

    test_reset_values();
    test_limit_edges();
    test_saturation();
    test_random_phases();

    // Collect whatever is still owed, then give the pipeline time to show
    // any stray word it should not have produced.
    release_push();
    waited = 0;
    while (drive_results_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (drive_results_due.size() != 0) begin
      error_count++;
      $display("%0t: %0d result words never arrived, expected 0 outstanding actual %0d",
               $time, drive_results_due.size(), drive_results_due.size());
    end
    repeat (SETTLE_CYCLES * 4) @(posedge clk);

    $display("Sent %0d ADC sequences and checked %0d result words under %0d register settings.",
             words_sent, results_checked, settings_used);
    $display("Covered clamp edges, map and duty saturation, frozen filter, %0d register writes.",
             reg_writes);
    if (error_count == 0) begin
      $display("levitation_position_drive: match");
    end else begin
      $display("levitation_position_drive: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/lpd_pkg.sv
sv/lpd_front.sv
sv/lpd_midq.sv
sv/lpd_back.sv
sv/levitation_position_drive.sv
sv/lpd_checker.sv
test/levitation_position_drive_tb.sv
